FILE: rtl/ldfs_pkg.sv
// Shared types and constants for the LED display frame serializer.
// No dependencies; every other file in this folder imports this package.
`default_nettype none

package ldfs_pkg;

   localparam int unsigned DIGIT_COUNT = 6;

   localparam logic [7:0] CMD_DATA = 8'h44;
   localparam logic [7:0] CMD_ADDR = 8'hC0;
   localparam logic [7:0] CMD_OFF  = 8'h80;
   localparam logic [7:0] CMD_ON   = 8'h88;

   localparam logic [3:0] BRIGHTNESS_OFF   = 4'hF;
   localparam logic [3:0] BRIGHTNESS_RESET = 4'h7;

   localparam logic [1:0] TICKS_START = 2'd3;
   localparam logic [1:0] TICKS_OTHER = 2'd2;

   localparam logic [3:0] ACK_SLOT = 4'd8;

   typedef struct packed {
      logic       rejected;
      logic [7:0] addr_byte;
      logic [7:0] seg_byte;
      logic [7:0] ctrl_byte;
   } cmd_type;

   typedef struct packed {
      logic       clk_first;
      logic       clk_second;
      logic       dat_first;
      logic       dat_second;
      logic [1:0] dat_ticks;
      logic       rejected;
      logic       last;
   } sym_type;

   function automatic sym_type make_sym(logic c0, logic c1, logic d0, logic d1,
                                        logic [1:0] ticks, logic rej, logic lst);
      sym_type s;
      s.clk_first  = c0;
      s.clk_second = c1;
      s.dat_first  = d0;
      s.dat_second = d1;
      s.dat_ticks  = ticks;
      s.rejected   = rej;
      s.last       = lst;
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/ldfs_front.sv
// Front end: checks the digit address and builds the three command bytes.
// Depends on ldfs_pkg.
`default_nettype none

module ldfs_front (
   input  wire logic [2:0]       digit_address,
   input  wire logic [7:0]       segment_pattern,
   input  wire logic [3:0]       brightness_level,
   output ldfs_pkg::cmd_type     cmd
);
   import ldfs_pkg::*;

   always_comb begin
      cmd.rejected  = (digit_address >= 3'(DIGIT_COUNT));
      cmd.addr_byte = CMD_ADDR | {5'd0, digit_address};
      cmd.seg_byte  = segment_pattern;
      if (brightness_level == BRIGHTNESS_OFF) begin
         cmd.ctrl_byte = CMD_OFF;
      end else begin
         cmd.ctrl_byte = CMD_ON | {5'd0, brightness_level[2:0]};
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ldfs_queue.sv
// Two-entry command queue between the front end and the symbol sequencer.
// Depends on ldfs_pkg.
`default_nettype none

module ldfs_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  ldfs_pkg::cmd_type      push_cmd,
   output logic                   full,
   input  wire logic              pop,
   output logic                   not_empty,
   output ldfs_pkg::cmd_type      head_cmd
);
   import ldfs_pkg::*;

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ldfs_back.sv
// Symbol sequencer: walks the three frames of one command, one symbol per cycle
// while its result register is free or popped. Depends on ldfs_pkg.
`default_nettype none

module ldfs_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   input  ldfs_pkg::cmd_type      cmd,
   output logic                   cmd_pop,
   input  wire logic              rsp_pop,
   output logic                   rsp_empty,
   output ldfs_pkg::sym_type      rsp_sym
);
   import ldfs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_BITS,
      ST_STOP
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   cmd_type    cur_ff;
   cmd_type    cur_in;
   logic [1:0] frame_ff;
   logic [1:0] frame_in;
   logic       byte_sel_ff;
   logic       byte_sel_in;
   logic [3:0] bit_ff;
   logic [3:0] bit_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   sym_type    out_ff;
   sym_type    out_in;
   logic       adv;
   logic [7:0] cur_byte;
   logic       data_bit;

   assign adv       = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_sym   = out_ff;
   assign cmd_pop   = adv && (state_ff == ST_IDLE) && cmd_valid;

   always_comb begin
      unique case (frame_ff)
         2'd0:    cur_byte = CMD_DATA;
         2'd1:    cur_byte = byte_sel_ff ? cur_ff.seg_byte : cur_ff.addr_byte;
         default: cur_byte = cur_ff.ctrl_byte;
      endcase
      data_bit = cur_byte[bit_ff[2:0]];
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      frame_in     = frame_ff;
      byte_sel_in  = byte_sel_ff;
      bit_in       = bit_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      if (adv) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cur_in       = cmd;
                  out_valid_in = 1'b1;
                  if (cmd.rejected) begin
                     out_in = make_sym(1'b1, 1'b1, 1'b1, 1'b1, TICKS_OTHER, 1'b1, 1'b1);
                  end else begin
                     out_in      = make_sym(1'b1, 1'b1, 1'b0, 1'b0, TICKS_START, 1'b0, 1'b0);
                     frame_in    = 2'd0;
                     byte_sel_in = 1'b0;
                     bit_in      = 4'd0;
                     state_in    = ST_BITS;
                  end
               end
            end
            ST_START: begin
               out_valid_in = 1'b1;
               out_in       = make_sym(1'b1, 1'b1, 1'b0, 1'b0, TICKS_START, 1'b0, 1'b0);
               byte_sel_in  = 1'b0;
               bit_in       = 4'd0;
               state_in     = ST_BITS;
            end
            ST_BITS: begin
               out_valid_in = 1'b1;
               if (bit_ff == ACK_SLOT) begin
                  out_in = make_sym(1'b0, 1'b1, 1'b0, 1'b0, TICKS_OTHER, 1'b0, 1'b0);
                  if ((frame_ff == 2'd1) && !byte_sel_ff) begin
                     byte_sel_in = 1'b1;
                     bit_in      = 4'd0;
                  end else begin
                     state_in = ST_STOP;
                  end
               end else begin
                  out_in = make_sym(1'b0, 1'b1, data_bit, data_bit, TICKS_OTHER, 1'b0, 1'b0);
                  bit_in = bit_ff + 4'd1;
               end
            end
            ST_STOP: begin
               out_valid_in = 1'b1;
               out_in = make_sym(1'b0, 1'b0, 1'b1, 1'b0, TICKS_OTHER, 1'b0,
                                 frame_ff == 2'd2);
               if (frame_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  frame_in = frame_ff + 2'd1;
                  state_in = ST_START;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         frame_ff     <= 2'd0;
         byte_sel_ff  <= 1'b0;
         bit_ff       <= 4'd0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         frame_ff     <= frame_in;
         byte_sel_ff  <= byte_sel_in;
         bit_ff       <= bit_in;
      end
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   a_reject_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.rejected) |-> out_ff.last)
      else $error("A rejected result must also be the last one.");

   a_bit_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BITS) |-> (bit_ff <= ACK_SLOT) && (frame_ff != 2'd3))
      else $error("Bit or frame counter left its range.");

   a_final_stop: assert property (@(posedge clock) disable iff (reset)
      (adv && (state_ff == ST_STOP) && (frame_ff == 2'd2)) |=>
         (state_ff == ST_IDLE) && out_valid_ff && out_ff.last)
      else $error("Final stop symbol did not end the sequence.");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (state_ff == ST_IDLE) && cmd_valid)
      else $error("Command taken while a sequence was running.");

endmodule

`default_nettype wire

FILE: rtl/led_display_frame_serializer_core.sv
// Top level of the LED display frame serializer.
// Depends on ldfs_pkg, ldfs_front, ldfs_queue and ldfs_back.
`default_nettype none

// Each accepted write turns into 42 result transfers, one waveform symbol each, or into a
// single transfer with rejected set when the digit address is 6 or more. The sequencer emits
// one symbol per cycle while the result register is free or being popped; that sequencer
// sets the sustained rate. A two-entry queue in front of it takes up to two writes
// while a sequence is running. The brightness register is read when a write is accepted.
module led_display_frame_serializer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [2:0] req_digit_address,
   input  wire logic [7:0] req_segment_pattern,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic            rsp_clock_first_half,
   output logic            rsp_clock_second_half,
   output logic            rsp_data_first_half,
   output logic            rsp_data_second_half,
   output logic [1:0]      rsp_data_second_ticks,
   output logic            rsp_rejected,
   output logic            rsp_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [3:0] csr_brightness_level
);
   import ldfs_pkg::*;

   logic [3:0] brightness_ff;
   cmd_type    front_cmd;
   cmd_type    head_cmd;
   logic       head_valid;
   logic       head_pop;
   sym_type    sym;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RESET;
      end else if (csr_valid && csr_ready) begin
         brightness_ff <= csr_brightness_level;
      end
   end

   ldfs_front u_front (
      .digit_address    (req_digit_address),
      .segment_pattern  (req_segment_pattern),
      .brightness_level (brightness_ff),
      .cmd              (front_cmd)
   );

   ldfs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_cmd  (front_cmd),
      .full      (req_full),
      .pop       (head_pop),
      .not_empty (head_valid),
      .head_cmd  (head_cmd)
   );

   ldfs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (head_valid),
      .cmd       (head_cmd),
      .cmd_pop   (head_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_sym   (sym)
   );

   assign rsp_clock_first_half  = sym.clk_first;
   assign rsp_clock_second_half = sym.clk_second;
   assign rsp_data_first_half   = sym.dat_first;
   assign rsp_data_second_half  = sym.dat_second;
   assign rsp_data_second_ticks = sym.dat_ticks;
   assign rsp_rejected          = sym.rejected;
   assign rsp_last              = sym.last;

endmodule

`default_nettype wire

FILE: tb/led_display_frame_serializer_core_tb.sv
// Self-checking testbench for the LED display frame serializer top level.
// Depends on ldfs_pkg and led_display_frame_serializer_core; predicts every waveform symbol
// of each digit write from the brightness setting and compares each result transfer.
`default_nettype none

module led_display_frame_serializer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ldfs_pkg::*;

   localparam int unsigned HOLD_OFF_CYCLES = 400;

   typedef struct packed {
      logic       clk_first;
      logic       clk_second;
      logic       dat_first;
      logic       dat_second;
      logic [1:0] ticks;
      logic       rejected;
      logic       last;
   } waveform_symbol_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [2:0] req_digit_address = '0;
   logic [7:0] req_segment_pattern = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_clock_first_half;
   logic       rsp_clock_second_half;
   logic       rsp_data_first_half;
   logic       rsp_data_second_half;
   logic [1:0] rsp_data_second_ticks;
   logic       rsp_rejected;
   logic       rsp_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [3:0] csr_brightness_level = '0;

   waveform_symbol_type pending_symbols[$];
   logic [3:0]          brightness_shadow = BRIGHTNESS_RESET;
   logic                no_idle = 1'b0;
   logic                hold_off_request = 1'b0;
   int unsigned         error_count = 0;
   int unsigned         writes_sent = 0;
   int unsigned         writes_rejected = 0;
   int unsigned         symbols_checked = 0;
   int unsigned         brightness_writes = 0;

   led_display_frame_serializer_core u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_digit_address     (req_digit_address),
      .req_segment_pattern   (req_segment_pattern),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_clock_first_half  (rsp_clock_first_half),
      .rsp_clock_second_half (rsp_clock_second_half),
      .rsp_data_first_half   (rsp_data_first_half),
      .rsp_data_second_half  (rsp_data_second_half),
      .rsp_data_second_ticks (rsp_data_second_ticks),
      .rsp_rejected          (rsp_rejected),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_brightness_level  (csr_brightness_level)
   );

   always #1 clock = ~clock;

   function automatic void queue_symbol(logic c0, logic c1, logic d0, logic d1,
                                        logic [1:0] ticks);
      waveform_symbol_type s;
      s = '{c0, c1, d0, d1, ticks, 1'b0, 1'b0};
      pending_symbols.push_back(s);
   endfunction

   function automatic void queue_frame(logic [15:0] octets, int unsigned count);
      logic [7:0] octet;
      queue_symbol(1'b1, 1'b1, 1'b0, 1'b0, TICKS_START);
      for (int unsigned i = 0; i < count; i++) begin
         octet = octets[8*i +: 8];
         for (int unsigned j = 0; j < 8; j++) begin
            queue_symbol(1'b0, 1'b1, octet[j], octet[j], TICKS_OTHER);
         end
         queue_symbol(1'b0, 1'b1, 1'b0, 1'b0, TICKS_OTHER);
      end
      queue_symbol(1'b0, 1'b0, 1'b1, 1'b0, TICKS_OTHER);
   endfunction

   function automatic void predict_write(logic [2:0] addr, logic [7:0] seg);
      logic [7:0] ctrl;
      if (addr >= DIGIT_COUNT) begin
         pending_symbols.push_back('{1'b1, 1'b1, 1'b1, 1'b1, TICKS_OTHER, 1'b1, 1'b1});
         writes_rejected++;
         return;
      end
      if (brightness_shadow == BRIGHTNESS_OFF) begin
         ctrl = CMD_OFF;
      end else begin
         ctrl = CMD_ON | {5'd0, brightness_shadow[2:0]};
      end
      queue_frame({8'h00, CMD_DATA}, 1);
      queue_frame({seg, CMD_ADDR | {5'd0, addr}}, 2);
      queue_frame({8'h00, ctrl}, 1);
      pending_symbols[pending_symbols.size() - 1].last = 1'b1;
   endfunction

   function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : symbol_checker
      waveform_symbol_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_symbols.size() == 0) begin
            $error("symbol transfer arrived with no write outstanding");
            error_count++;
         end else begin
            want = pending_symbols.pop_front();
            check_field("clock_first_half", want.clk_first, rsp_clock_first_half);
            check_field("clock_second_half", want.clk_second, rsp_clock_second_half);
            check_field("data_first_half", want.dat_first, rsp_data_first_half);
            check_field("data_second_half", want.dat_second, rsp_data_second_half);
            check_field("data_second_ticks", want.ticks, rsp_data_second_ticks);
            check_field("rejected", want.rejected, rsp_rejected);
            check_field("last", want.last, rsp_last);
            symbols_checked++;
         end
      end
   end

   // The receiver normally pops most cycles; a hold-off request blocks it for a long stretch.
   initial begin : pop_driver
      int unsigned hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= no_idle || ($urandom_range(99) >= 10);
         end
      end
   end

   task automatic send_write(input logic [2:0] addr, input logic [7:0] seg);
      int unsigned gap;
      gap = 0;
      if (!no_idle && $urandom_range(99) < 10) begin
         gap = $urandom_range(6, 1);
      end
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push            <= 1'b1;
      req_digit_address   <= addr;
      req_segment_pattern <= seg;
      do @(posedge clock); while (req_full);
      predict_write(addr, seg);
      writes_sent++;
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
   endtask

   task automatic write_brightness(input logic [3:0] level);
      csr_valid            <= 1'b1;
      csr_brightness_level <= level;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      brightness_shadow = level;
      brightness_writes++;
   endtask

   function automatic logic [2:0] random_address();
      if ($urandom_range(99) < 15) begin
         return 3'($urandom_range(7, 6));
      end
      return 3'($urandom_range(5, 0));
   endfunction

   function automatic logic [3:0] random_brightness();
      if ($urandom_range(99) < 15) begin
         return 4'($urandom_range(14, 8));
      end
      if ($urandom_range(8) == 8) begin
         return BRIGHTNESS_OFF;
      end
      return 4'($urandom_range(7, 0));
   endfunction

   task automatic test_directed_fields();
      send_write(3'd0, 8'h00);
      send_write(3'd5, 8'hFF);
      send_write(3'd6, 8'hFF);
      send_write(3'd7, 8'h00);
      send_write(3'd3, 8'hA5);
      send_write(3'd4, 8'h5A);
      wait_drained();
   endtask

   task automatic test_brightness_codes();
      logic [3:0] codes[6];
      codes = '{BRIGHTNESS_OFF, 4'd0, 4'd7, 4'd8, 4'hE, 4'd3};
      foreach (codes[i]) begin
         write_brightness(codes[i]);
         send_write(3'($urandom_range(5, 0)), 8'($urandom));
         send_write(3'd1, 8'h81);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      hold_off_request = 1'b1;
      repeat (12) send_write(random_address(), 8'($urandom));
      wait_drained();
   endtask

   task automatic test_random_writes();
      for (int unsigned blk = 0; blk < 6; blk++) begin
         write_brightness(random_brightness());
         no_idle = (blk == 2);
         repeat (38) send_write(random_address(), 8'($urandom));
         wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_fields();
      test_brightness_codes();
      test_backpressure();
      test_random_writes();
      wait_drained();
      repeat (50) @(posedge clock);
      $display("Covered %0d digit writes (%0d rejected) over %0d brightness settings.",
               writes_sent, writes_rejected, brightness_writes);
      $display("Checked %0d waveform symbol transfers, %0d mismatches.",
               symbols_checked, error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Timed out with %0d symbols still outstanding.", pending_symbols.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
